/* rtl/top_k_best_score_table_assert.svh */
// Assertion macros for the top-k score table.
// Both forms expect clk and rst_n to be visible where they are used.
`ifndef TOP_K_BEST_SCORE_TABLE_ASSERT_SVH
`define TOP_K_BEST_SCORE_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TKBST_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tkbst: invariant violated");

`define TKBST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkbst: sequence check failed");

`else

`define TKBST_ASSERT(label, cond)

`define TKBST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/tkbst_pkg.sv */
package tkbst_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_BYTES_DEF = 8;

    localparam int ACTION_W    = 2;
    localparam int IN_KEY_W    = 64;
    localparam int SCORE_W     = 32;
    localparam int LEVEL_W     = 16;
    localparam int INDEX_W     = 4;
    localparam int COUNT_OUT_W = 5;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the pending item
        logic ins_en;   // commit an insertion this cycle
        logic found;    // pending key already held somewhere in the chain
    } cell_ctrl_t;

endpackage

/* rtl/tkbst_cell.sv */
module tkbst_cell #(
    parameter int IDX   = 0,
    parameter int KEY_W = 64,
    parameter int IW    = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tkbst_pkg::cell_ctrl_t        ctrl,
    input  logic                         occ,
    input  logic [IW-1:0]                match_idx,
    input  logic [KEY_W-1:0]             new_key,
    input  logic signed [tkbst_pkg::SCORE_W-1:0] new_score,
    input  logic [tkbst_pkg::LEVEL_W-1:0] new_level,
    input  logic                         left_ge,
    input  logic [KEY_W-1:0]             left_key,
    input  logic signed [tkbst_pkg::SCORE_W-1:0] left_score,
    input  logic [tkbst_pkg::LEVEL_W-1:0] left_level,
    output logic [KEY_W-1:0]             key,
    output logic signed [tkbst_pkg::SCORE_W-1:0] score,
    output logic [tkbst_pkg::LEVEL_W-1:0] level,
    output logic                         ge,
    output logic                         match
);
    import tkbst_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [KEY_W-1:0]          key_reg, key_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic [LEVEL_W-1:0]        level_reg, level_next;
    logic                      ge_reg, ge_next;
    logic                      match_reg, match_next;
    logic                      load_new, shift_in;

    // Left neighbour at or above the new score and this one below: insertion point.
    // Cells past it move down one place, up to the old slot of a matching key.
    assign load_new = ctrl.ins_en && left_ge && !ge_reg;
    assign shift_in = ctrl.ins_en && !left_ge && (!ctrl.found || (MY_IDX <= match_idx));

    always_comb
    begin
        ge_next    = ge_reg;
        match_next = match_reg;
        if (ctrl.cmp_en)
        begin
            ge_next    = occ && (score_reg >= new_score);
            match_next = occ && (key_reg == new_key);
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        score_next = score_reg;
        level_next = level_reg;
        if (load_new)
        begin
            key_next   = new_key;
            score_next = new_score;
            level_next = new_level;
        end
        else if (shift_in)
        begin
            key_next   = left_key;
            score_next = left_score;
            level_next = left_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg    <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            ge_reg    <= ge_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        score_reg <= score_next;
        level_reg <= level_next;
    end

    assign key   = key_reg;
    assign score = score_reg;
    assign level = level_reg;
    assign ge    = ge_reg;
    assign match = match_reg;

endmodule

/* rtl/tkbst_enc.sv */
module tkbst_enc #(
    parameter int N  = 16,
    parameter int IW = 4
) (
    input  logic [N-1:0]  vec,
    output logic [IW-1:0] idx,
    output logic          found
);
    logic [IW-1:0] idx_v;

    // vec is one-hot or empty, so OR-ing the indices of set bits gives the position
    always_comb
    begin
        idx_v = '0;
        for (int i = 0; i < N; i++)
        begin
            if (vec[i])
            begin
                idx_v = idx_v | IW'(i);
            end
        end
    end

    assign idx   = idx_v;
    assign found = |vec;

endmodule

/* rtl/top_k_best_score_table.sv */
// Top-k score table: a chain of CAPACITY cells kept sorted by descending score.
// Flow: each item is taken in while idle, then passes a compare state and an update
// state before the registered result appears. A new item is accepted only when idle,
// so the compare/update pass over the cell chain, the single item slot and any stall on the output side set the rate.
// Reset: asynchronous, active low; empties the table and drops any pending item.
`include "top_k_best_score_table_assert.svh"

module top_k_best_score_table #(
    parameter int CAPACITY  = tkbst_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES = tkbst_pkg::KEY_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tkbst_pkg::ACTION_W-1:0]      action,
    input  logic [tkbst_pkg::IN_KEY_W-1:0]      entry_key,
    input  logic signed [tkbst_pkg::SCORE_W-1:0] new_score,
    input  logic [tkbst_pkg::LEVEL_W-1:0]       new_level,
    input  logic [tkbst_pkg::INDEX_W-1:0]       read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                inserted,
    output logic                                read_valid,
    output logic [tkbst_pkg::IN_KEY_W-1:0]      read_key,
    output logic signed [tkbst_pkg::SCORE_W-1:0] read_score,
    output logic [tkbst_pkg::LEVEL_W-1:0]       read_level,
    output logic [tkbst_pkg::COUNT_OUT_W-1:0]   entry_count
);
    import tkbst_pkg::*;

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMPW  = (CW > INDEX_W) ? CW : INDEX_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [ACTION_W-1:0]       act_reg;
    logic [KEY_W-1:0]          key_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [LEVEL_W-1:0]        level_reg;
    logic [INDEX_W-1:0]        idx_reg;

    logic [CW-1:0] count_reg, count_next;

    logic                      out_valid_reg;
    logic                      ins_out_reg, rvalid_reg;
    logic [KEY_W-1:0]          rkey_reg;
    logic signed [SCORE_W-1:0] rscore_reg;
    logic [LEVEL_W-1:0]        rlevel_reg;

    logic [KEY_W-1:0]          cell_key [CAPACITY];
    logic signed [SCORE_W-1:0] cell_score [CAPACITY];
    logic [LEVEL_W-1:0]        cell_level [CAPACITY];
    logic [CAPACITY-1:0]       ge_vec, match_vec, occ_vec;

    logic [IW-1:0] match_idx;
    logic          found;
    logic          not_improved, do_ins, go, accept;
    logic          is_add, is_read, is_clear;
    cell_ctrl_t    ctrl;

    logic [CMPW-1:0] idx_ext, cnt_ext;
    logic [IW-1:0]   rd_sel;
    logic            rd_hit;
    logic [CW+COUNT_OUT_W-1:0] cnt_wide;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign go       = (state_reg == S_UPD) && (!out_valid_reg || out_ready);

    assign is_add   = (act_reg == ACT_ADD);
    assign is_read  = (act_reg == ACT_READ);
    assign is_clear = (act_reg == ACT_CLEAR);

    tkbst_enc #(
        .N  (CAPACITY),
        .IW (IW)
    ) u_enc (
        .vec   (match_vec),
        .idx   (match_idx),
        .found (found)
    );

    // Held key with a score not below the new one blocks the add; without a
    // match, a full prefix of higher-or-equal scores pushes it off the end.
    assign not_improved = |(match_vec & ge_vec);
    assign do_ins = found ? !not_improved : !ge_vec[CAPACITY-1];

    assign ctrl.cmp_en = (state_reg == S_CMP);
    assign ctrl.ins_en = go && is_add && do_ins;
    assign ctrl.found  = found;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                      l_ge;
            logic [KEY_W-1:0]          l_key;
            logic signed [SCORE_W-1:0] l_score;
            logic [LEVEL_W-1:0]        l_level;

            assign occ_vec[gi] = (count_reg > CW'(gi));

            if (gi == 0)
            begin : g_head
                assign l_ge    = 1'b1;
                assign l_key   = key_reg;
                assign l_score = score_reg;
                assign l_level = level_reg;
            end
            else
            begin : g_body
                assign l_ge    = ge_vec[gi-1];
                assign l_key   = cell_key[gi-1];
                assign l_score = cell_score[gi-1];
                assign l_level = cell_level[gi-1];
            end

            tkbst_cell #(
                .IDX   (gi),
                .KEY_W (KEY_W),
                .IW    (IW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .occ        (occ_vec[gi]),
                .match_idx  (match_idx),
                .new_key    (key_reg),
                .new_score  (score_reg),
                .new_level  (level_reg),
                .left_ge    (l_ge),
                .left_key   (l_key),
                .left_score (l_score),
                .left_level (l_level),
                .key        (cell_key[gi]),
                .score      (cell_score[gi]),
                .level      (cell_level[gi]),
                .ge         (ge_vec[gi]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    assign idx_ext = CMPW'(idx_reg);
    assign cnt_ext = CMPW'(count_reg);
    assign rd_hit  = idx_ext < cnt_ext;
    assign rd_sel  = idx_ext[IW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (go)
        begin
            if (is_clear)
            begin
                count_next = '0;
            end
            else if (ctrl.ins_en && !found && (count_reg < CAP_C))
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            key_reg   <= entry_key[KEY_W-1:0];
            score_reg <= new_score;
            level_reg <= new_level;
            idx_reg   <= read_index;
        end
        if (go)
        begin
            ins_out_reg <= ctrl.ins_en;
            rvalid_reg  <= is_read && rd_hit;
            if (is_read && rd_hit)
            begin
                rkey_reg   <= cell_key[rd_sel];
                rscore_reg <= cell_score[rd_sel];
                rlevel_reg <= cell_level[rd_sel];
            end
            else
            begin
                rkey_reg   <= '0;
                rscore_reg <= '0;
                rlevel_reg <= '0;
            end
        end
    end

    assign cnt_wide = (CW + COUNT_OUT_W)'(count_reg);

    assign out_valid   = out_valid_reg;
    assign inserted    = ins_out_reg;
    assign read_valid  = rvalid_reg;
    assign read_key    = IN_KEY_W'(rkey_reg);
    assign read_score  = rscore_reg;
    assign read_level  = rlevel_reg;
    assign entry_count = cnt_wide[COUNT_OUT_W-1:0];

    `TKBST_ASSERT(a_count_bound, count_reg <= CAP_C)
    `TKBST_ASSERT(a_single_match, (state_reg != S_UPD) || $onehot0(match_vec))
    `TKBST_ASSERT(a_sorted_prefix, (state_reg != S_UPD) || (((ge_vec + 1'b1) & ge_vec) == '0))
    `TKBST_ASSERT_NEXT(a_clear_empties, go && is_clear, count_reg == '0)

endmodule
